// ----- hdl/lphs_pkg.sv -----
// Package: shared constants, status codes and controller/datapath command and status types.
`timescale 1ns / 1ps
package lphs_pkg;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned KEY_IN_W = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned BUCKET_W = 8;
    localparam int unsigned COUNT_W  = 9;

    localparam logic [31:0] HASH_MUL   = 32'h045d9f3b;
    localparam int unsigned HASH_SHIFT = 16;

    localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;    // write empty key at clear address, advance
        logic load;        // capture request fields
        logic hash_step;   // advance the hash unit one stage
        logic set_probe;   // probe pointer <- hashed home (search)
        logic rd;          // issue memory read at probe pointer
        logic adv;         // probe pointer + 1, step counter + 1
        logic wr_key;      // write request key at probe pointer, count + 1
        logic dec_cnt;     // count - 1
        logic set_hole;    // hole <- probe pointer (found bucket)
        logic gap_init;    // scan pointer <- probe pointer (the new hole)
        logic gap_rd;      // scan pointer + 1 and read it
        logic gap_hash;    // load scanned key into the hash unit
        logic gap_move;    // write scanned key into hole, hole <- scan
        logic gap_close;   // write empty key into hole
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic key_bad;
        logic full;
        logic rd_empty;
        logic rd_match;
        logic probe_done;   // all buckets visited
        logic scan_wrapped; // scan pointer came back to start
        logic move_ok;
        logic [1:0] mode;
        logic check;
    } t_sts;
endpackage

// ----- hdl/lphs_if.sv -----
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface lphs_req_if;
    logic                            valid;
    logic                            ready;
    logic [lphs_pkg::MODE_W-1:0]     mode;
    logic [lphs_pkg::KEY_IN_W-1:0]   key;
    logic                            check_duplicate;
    modport source (output valid, mode, key, check_duplicate, input ready);
    modport sink   (input valid, mode, key, check_duplicate, output ready);
endinterface

interface lphs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [lphs_pkg::STATUS_W-1:0]   status;
    logic [lphs_pkg::BUCKET_W-1:0]   bucket;
    logic [lphs_pkg::COUNT_W-1:0]    count;
    modport source (output valid, status, bucket, count, input ready);
    modport sink   (input valid, status, bucket, count, output ready);
endinterface

// ----- hdl/lphs_datapath.sv -----
// Datapath: bucket memory, iterative hash unit, probe and hole pointers, count.
`timescale 1ns / 1ps
module lphs_datapath #(
    parameter int unsigned NUM_BUCKETS = 256,
    parameter int unsigned KEY_WIDTH   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lphs_pkg::t_cmd                    i_cmd,
    input  logic [lphs_pkg::MODE_W-1:0]       i_mode,
    input  logic [lphs_pkg::KEY_IN_W-1:0]     i_key,
    input  logic                              i_check,
    output lphs_pkg::t_sts                    o_sts,
    output logic [lphs_pkg::BUCKET_W-1:0]     o_bucket,
    output logic [lphs_pkg::COUNT_W-1:0]      o_count
);
    localparam int unsigned IW = $clog2(NUM_BUCKETS);
    localparam int unsigned CW = IW + 1;
    localparam logic [KEY_WIDTH-1:0] EMPTY = {KEY_WIDTH{1'b1}};

    logic [KEY_WIDTH-1:0] r_mem [NUM_BUCKETS];
    logic [KEY_WIDTH-1:0] r_rd_data;
    logic [KEY_WIDTH-1:0] r_key;
    logic [lphs_pkg::MODE_W-1:0] r_mode;
    logic r_check;
    logic [31:0] r_h;
    logic [IW-1:0] r_probe, r_hole, r_scan, r_clr;
    logic [CW-1:0] r_steps, r_cnt;
    logic r_clr_done;
    // Start of the gap scan, for the wraparound stop.
    logic [IW-1:0] r_hole_start;

    // Hash: each step applies (h>>16)^h then one multiply; registered between.
    logic [31:0] w_mix;
    logic [63:0] w_prod;
    logic [IW-1:0] w_home;
    assign w_mix  = (r_h >> lphs_pkg::HASH_SHIFT) ^ r_h;
    assign w_prod = 64'(w_mix) * 64'(lphs_pkg::HASH_MUL);
    assign w_home = w_mix[IW-1:0];

    logic [IW-1:0] w_scan_nx;
    assign w_scan_nx = r_scan + 1'b1;

    logic w_move;
    always_comb begin
        if (r_hole < r_scan) begin
            w_move = (w_home <= r_hole) || (w_home > r_scan);
        end else begin
            w_move = (w_home <= r_hole) && (w_home > r_scan);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr] <= EMPTY;
        end else if (i_cmd.wr_key) begin
            r_mem[r_probe] <= r_key;
        end else if (i_cmd.gap_move) begin
            r_mem[r_hole] <= r_rd_data;
        end else if (i_cmd.gap_close) begin
            r_mem[r_hole] <= EMPTY;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_probe];
        end else if (i_cmd.gap_rd) begin
            r_rd_data <= r_mem[w_scan_nx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == IW'(NUM_BUCKETS - 1)) r_clr_done <= 1'b1;
            end
            if (i_cmd.wr_key) r_cnt <= r_cnt + 1'b1;
            else if (i_cmd.dec_cnt && r_cnt != '0) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_key[KEY_WIDTH-1:0];
            r_mode  <= i_mode;
            r_check <= i_check;
            r_h     <= 32'(i_key[KEY_WIDTH-1:0]);
        end else if (i_cmd.gap_hash) begin
            r_h <= 32'(r_rd_data);
        end else if (i_cmd.hash_step) begin
            r_h <= w_prod[31:0];
        end
        if (i_cmd.set_probe) begin
            r_probe <= w_home;
            r_steps <= '0;
        end else if (i_cmd.adv) begin
            r_probe <= r_probe + 1'b1;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.set_hole) begin
            r_hole <= r_probe;
        end else if (i_cmd.gap_move) begin
            r_hole <= r_scan;
        end
        if (i_cmd.gap_init) begin
            r_scan <= r_probe;
        end else if (i_cmd.gap_rd) begin
            r_scan <= w_scan_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gap_init) r_hole_start <= r_probe;
    end

    assign o_sts.clr_done     = r_clr_done;
    assign o_sts.key_bad      = (r_key == EMPTY);
    assign o_sts.full         = (r_cnt >= CW'(NUM_BUCKETS));
    assign o_sts.rd_empty     = (r_rd_data == EMPTY);
    assign o_sts.rd_match     = (r_rd_data == r_key);
    assign o_sts.probe_done   = (r_steps == CW'(NUM_BUCKETS));
    assign o_sts.scan_wrapped = (r_scan == r_hole_start);
    assign o_sts.move_ok      = w_move;
    assign o_sts.mode         = r_mode;
    assign o_sts.check        = r_check;

    assign o_bucket = lphs_pkg::BUCKET_W'(r_probe);
    assign o_count  = lphs_pkg::COUNT_W'(r_cnt);
endmodule

// ----- hdl/lphs_ctrl.sv -----
// Controller: sequences clearing, hashing, probing and backward-shift deletion.
`timescale 1ns / 1ps
module lphs_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output logic [lphs_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_bucket_sel,
    output lphs_pkg::t_cmd                  o_cmd,
    input  lphs_pkg::t_sts                  i_sts
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_HASH, S_READ, S_EVAL,
        S_GAP_RD, S_GAP_EVAL, S_GAP_H1, S_GAP_H2, S_GAP_H3, S_GAP_DEC, S_RESP
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_hcnt, n_hcnt;
    logic [lphs_pkg::STATUS_W-1:0] r_status, n_status;
    logic r_bsel, n_bsel;

    always_comb begin
        n_state  = r_state;
        n_hcnt   = r_hcnt;
        n_status = r_status;
        n_bsel   = r_bsel;
        o_cmd    = '0;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
                else o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_hcnt = '0;
                n_bsel = 1'b0;
                if (i_sts.key_bad || i_sts.mode == lphs_pkg::MODE_RESERVED) begin
                    n_status = lphs_pkg::ST_INVALID;
                    n_state  = S_RESP;
                end else if (i_sts.mode == lphs_pkg::MODE_INSERT && i_sts.full) begin
                    n_status = lphs_pkg::ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (r_hcnt == 2'd2) begin
                    o_cmd.set_probe = 1'b1;
                    n_state = S_READ;
                end else begin
                    o_cmd.hash_step = 1'b1;
                    n_hcnt = r_hcnt + 1'b1;
                end
            end
            S_READ: begin
                if (i_sts.probe_done) begin
                    n_status = (i_sts.mode == lphs_pkg::MODE_INSERT) ?
                               lphs_pkg::ST_FULL : lphs_pkg::ST_MISSING;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.mode == lphs_pkg::MODE_INSERT) begin
                    if (i_sts.check && i_sts.rd_match) begin
                        n_status = lphs_pkg::ST_PRESENT;
                        n_bsel = 1'b1;
                        n_state = S_RESP;
                    end else if (i_sts.rd_empty) begin
                        o_cmd.wr_key = 1'b1;
                        n_status = lphs_pkg::ST_INSERTED;
                        n_bsel = 1'b1;
                        n_state = S_RESP;
                    end else begin
                        o_cmd.adv = 1'b1;
                        n_state = S_READ;
                    end
                end else if (i_sts.rd_empty) begin
                    n_status = lphs_pkg::ST_MISSING;
                    n_state  = S_RESP;
                end else if (i_sts.rd_match) begin
                    n_bsel = 1'b1;
                    if (i_sts.mode == lphs_pkg::MODE_LOOKUP) begin
                        n_status = lphs_pkg::ST_FOUND;
                        n_state  = S_RESP;
                    end else begin
                        n_status = lphs_pkg::ST_REMOVED;
                        o_cmd.set_hole = 1'b1;
                        o_cmd.gap_init = 1'b1;
                        o_cmd.dec_cnt  = 1'b1;
                        n_state = S_GAP_RD;
                    end
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state = S_READ;
                end
            end
            S_GAP_RD: begin
                o_cmd.gap_rd = 1'b1;
                n_state = S_GAP_EVAL;
            end
            S_GAP_EVAL: begin
                if (i_sts.scan_wrapped || i_sts.rd_empty) begin
                    o_cmd.gap_close = 1'b1;
                    n_state = S_RESP;
                end else begin
                    o_cmd.gap_hash = 1'b1;
                    n_state = S_GAP_H1;
                end
            end
            S_GAP_H1: begin
                o_cmd.hash_step = 1'b1;
                n_state = S_GAP_H2;
            end
            S_GAP_H2: begin
                o_cmd.hash_step = 1'b1;
                n_state = S_GAP_DEC;
            end
            S_GAP_DEC: begin
                if (i_sts.move_ok) o_cmd.gap_move = 1'b1;
                n_state = S_GAP_RD;
            end
            S_GAP_H3: n_state = S_GAP_RD;
            S_RESP: begin
                if (i_rsp_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_hcnt   <= '0;
            r_status <= lphs_pkg::ST_INVALID;
            r_bsel   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hcnt   <= n_hcnt;
            r_status <= n_status;
            r_bsel   <= n_bsel;
        end
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_rsp_valid  = (r_state == S_RESP);
    assign o_status     = r_status;
    assign o_bucket_sel = r_bsel;
endmodule

// ----- hdl/linear_probe_hash_set_core.sv -----
// Top level of the linear-probing hash set: controller, datapath and result stage.
`timescale 1ns / 1ps
// A set of keys held in an open-addressed table of NUM_BUCKETS buckets. Each
// request carries a mode (insert, lookup, remove), a key and a duplicate-check
// flag, and produces exactly one result with a status, the bucket of the key
// where one applies, and the number of stored keys afterwards. After reset the
// block writes every bucket empty and takes no request during that pass. One
// request is handled at a time: set-up and hashing (two multiply rounds through
// one shared 32x32 multiplier), then a read step and an evaluate step for each
// bucket visited on the probe run, since each visit is one registered read of
// the bucket memory. A removal then walks the cluster after the hole, reading
// and re-hashing each key to decide whether it shifts back.
module linear_probe_hash_set_core #(
    parameter int unsigned NUM_BUCKETS = 256,
    parameter int unsigned KEY_WIDTH   = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lphs_req_if.sink  i_req,
    lphs_rsp_if.source o_rsp
);
    lphs_pkg::t_cmd w_cmd;
    lphs_pkg::t_sts w_sts;
    logic [lphs_pkg::STATUS_W-1:0] w_status;
    logic w_bsel;
    logic [lphs_pkg::BUCKET_W-1:0] w_bucket;
    logic [lphs_pkg::COUNT_W-1:0]  w_count;

    lphs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .o_req_ready  (i_req.ready),
        .o_rsp_valid  (o_rsp.valid),
        .i_rsp_ready  (o_rsp.ready),
        .o_status     (w_status),
        .o_bucket_sel (w_bsel),
        .o_cmd        (w_cmd),
        .i_sts        (w_sts)
    );

    lphs_datapath #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_mode   (i_req.mode),
        .i_key    (i_req.key),
        .i_check  (i_req.check_duplicate),
        .o_sts    (w_sts),
        .o_bucket (w_bucket),
        .o_count  (w_count)
    );

    // During a removal the probe pointer still holds the found bucket, since
    // the gap walk uses its own scan and hole pointers.
    assign o_rsp.status = w_status;
    assign o_rsp.bucket = w_bsel ? w_bucket : '0;
    assign o_rsp.count  = w_count;

    // No result ever reports a count above the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.count <= lphs_pkg::COUNT_W'(NUM_BUCKETS)))
        else $error("stored count exceeds table size");

    // A fresh insert raises the count by exactly one.
    a_insert_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) && o_rsp.status == lphs_pkg::ST_INSERTED
        |-> o_rsp.count == $past(o_rsp.count, 1) + 1'b1)
        else $error("insert count mismatch");

    // The block is never ready for a request while a result is offered.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request accepted while a result is pending");

    // Invalid, full and missing results never carry a bucket.
    a_no_bucket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == lphs_pkg::ST_INVALID ||
        o_rsp.status == lphs_pkg::ST_FULL || o_rsp.status == lphs_pkg::ST_MISSING)
        |-> o_rsp.bucket == '0)
        else $error("bucket given for a status without one");
endmodule
